// ===== hw/rtl/asl_pkg.sv =====
// ----------------------------------------------------------------------------
// asl_pkg
// Shared types and constants for the angle slew limiter.
// ----------------------------------------------------------------------------
package asl_pkg;

    // Angle units are 2^-ANGLE_FRAC_BITS degree
    localparam int ANGLE_FRAC_BITS = 7;
    // Angle fields on the ports
    localparam int ANGLE_W = 16;
    // Step register width
    localparam int STEP_W  = 15;
    // Internal arithmetic width: holds sums of two 16-bit angles and a turn
    localparam int ACC_W   = 19;

    // Register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_SLEW_STEP = 1'b0;   // register index, paddr[2]
    localparam logic [STEP_W-1:0] STEP_RESET = 15'd128;

    typedef enum logic [1:0] {
        MODE_SHORTEST = 2'd0,
        MODE_CW       = 2'd1,
        MODE_CCW      = 2'd2
    } t_mode;

endpackage

// ===== hw/rtl/asl_step.sv =====
// ----------------------------------------------------------------------------
// asl_step
// One heading update: error by direction mode, clamp to step, wrap to +-180.
// ----------------------------------------------------------------------------
module asl_step (
    input  logic signed [asl_pkg::ANGLE_W-1:0] i_base,
    input  logic signed [asl_pkg::ANGLE_W-1:0] i_target,
    input  asl_pkg::t_mode                     i_mode,
    input  logic        [asl_pkg::STEP_W-1:0]  i_step,
    output logic signed [asl_pkg::ANGLE_W-1:0] o_heading
);
    import asl_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] FULL = ACC_W'(360 << ANGLE_FRAC_BITS);

    // Reduce d into [0, FULL); |d| stays below two turns
    function automatic logic signed [ACC_W-1:0] turn_mod(
        input logic signed [ACC_W-1:0] d
    );
        logic signed [ACC_W-1:0] r;
        begin
            if (d >= FULL) begin
                r = d - FULL;
            end else if (d >= 0) begin
                r = d;
            end else if (d >= -FULL) begin
                r = d + FULL;
            end else begin
                r = d + (FULL <<< 1);
            end
            if (r >= FULL) begin
                r = r - FULL;
            end
            return r;
        end
    endfunction

    logic signed [ACC_W-1:0] w_base;
    logic signed [ACC_W-1:0] w_tgt;
    logic signed [ACC_W-1:0] w_step;
    logic signed [ACC_W-1:0] w_fwd;
    logic signed [ACC_W-1:0] w_err;
    logic signed [ACC_W-1:0] w_mag;
    logic signed [ACC_W-1:0] w_next;
    logic signed [ACC_W-1:0] w_wrap_hi;
    logic signed [ACC_W-1:0] w_wrap;

    assign w_base = ACC_W'(i_base);
    assign w_tgt  = ACC_W'(i_target);
    assign w_step = $signed({{(ACC_W-STEP_W){1'b0}}, i_step});
    assign w_fwd  = w_tgt - w_base;

    always_comb begin
        case (i_mode)
            MODE_SHORTEST: begin
                if (w_fwd > HALF) begin
                    w_err = w_fwd - FULL;
                end else if (w_fwd < -HALF) begin
                    w_err = w_fwd + FULL;
                end else begin
                    w_err = w_fwd;
                end
            end
            MODE_CW: w_err = -turn_mod(w_base - w_tgt);
            default: w_err = turn_mod(w_fwd);   // counterclockwise
        endcase
    end

    assign w_mag = w_err[ACC_W-1] ? -w_err : w_err;

    always_comb begin
        if (w_mag <= w_step) begin
            w_next = w_tgt;
        end else if (w_err > 0) begin
            w_next = w_base + w_step;
        end else begin
            w_next = w_base - w_step;
        end
    end

    // Wrap once from above, then once from below
    assign w_wrap_hi = (w_next > HALF) ? w_next - FULL : w_next;
    assign w_wrap    = (w_wrap_hi < -HALF) ? w_wrap_hi + FULL : w_wrap_hi;
    assign o_heading = w_wrap[ANGLE_W-1:0];

endmodule

// ===== hw/rtl/angle_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// angle_slew_limiter
// Heading rate limiter with wraparound, 1/128 degree fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: each request carries a target heading and the measured
//   heading in tdata and a direction mode in tuser. Each request yields one
//   result on the output stream: the kept heading after stepping toward the
//   target by at most the slew step, wrapped into +-180 degrees.
//   The first request after reset seeds the kept heading from the measured
//   heading; later requests ignore the measured heading.
//   An accepted request passes through the input register, then the result
//   register. Throughput: one request per cycle while the receiver takes
//   results; the single update path between the input and result registers
//   sets that figure, and the kept heading written with each result feeds
//   the next request. Backpressure: when the receiver stalls, the result
//   register holds and the input register holds behind it; tready drops
//   only when both are full. Reset clears both valids, the seed flag and the
//   kept heading, and loads the slew step with 128 (one degree). The slew
//   step is to be written by the user over the APB port at address 0 only
//   while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module angle_slew_limiter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [asl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [asl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [asl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // Input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [31:0]                       i_s_axis_tdata,  // target_angle, measured_angle
    input  logic [1:0]                        i_s_axis_tuser,  // direction_mode
    // Output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [15:0]                       o_m_axis_tdata   // ramped_angle
);
    import asl_pkg::*;

    localparam logic signed [ANGLE_W-1:0] HALF_TURN =
        ANGLE_W'(180 << ANGLE_FRAC_BITS);

    // Configuration
    logic [STEP_W-1:0] r_step;

    // Input register
    logic                      r_s1_valid;
    logic signed [ANGLE_W-1:0] r_s1_target;
    logic signed [ANGLE_W-1:0] r_s1_measured;
    t_mode                     r_s1_mode;

    // Heading state
    logic signed [ANGLE_W-1:0] r_kept;
    logic                      r_seeded;

    // Result register
    logic                      r_out_valid;
    logic signed [ANGLE_W-1:0] r_out_data;

    logic                      w_in_accept;
    logic                      w_s1_move;
    logic                      w_cfg_write;
    logic signed [ANGLE_W-1:0] w_base;
    logic signed [ANGLE_W-1:0] n_kept;

    // ---------------------------------------------------------------- APB
    assign pready      = 1'b1;
    assign w_cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (w_cfg_write && paddr[2] == REG_SLEW_STEP) begin
            r_step <= pwdata[STEP_W-1:0];
        end
    end

    // Only the step register exists; addresses with paddr[2] set read as zero
    assign prdata = (paddr[2] == REG_SLEW_STEP) ?
                    {{(APB_DATA_W-STEP_W){1'b0}}, r_step} : '0;

    // ---------------------------------------------------------- handshake
    // Advance the input register whenever the result register frees up
    assign w_s1_move       = r_s1_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_s1_valid | w_s1_move;
    assign w_in_accept     = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_target   <= i_s_axis_tdata[15:0];
            r_s1_measured <= i_s_axis_tdata[31:16];
            r_s1_mode     <= t_mode'(i_s_axis_tuser);
        end
    end

    // ------------------------------------------------------------- update
    // Seed from the measured heading on the first request after reset
    assign w_base = r_seeded ? r_kept : r_s1_measured;

    asl_step u_step (
        .i_base    (w_base),
        .i_target  (r_s1_target),
        .i_mode    (r_s1_mode),
        .i_step    (r_step),
        .o_heading (n_kept)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept   <= '0;
            r_seeded <= 1'b0;
        end else if (w_s1_move) begin
            r_kept   <= n_kept;
            r_seeded <= 1'b1;
        end
    end

    // ------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_data <= n_kept;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // --------------------------------------------------------- assertions
    // The shown result is always the heading that the next request builds on
    a_out_matches_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data == r_kept))
        else $error("result register differs from kept heading");

    // A delivered heading is wrapped into +-180 degrees
    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data <= HALF_TURN && r_out_data >= -HALF_TURN))
        else $error("result heading outside half-turn range");

    // Once a request has been processed the heading is seeded
    a_seed_after_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_move |=> r_seeded)
        else $error("heading not seeded after first update");

endmodule
